@@ hw/rtl/convex_hull_line_container_defines.svh @@
// Assertion macros shared by the convex hull line container RTL.
`ifndef CONVEX_HULL_LINE_CONTAINER_DEFINES_SVH
`define CONVEX_HULL_LINE_CONTAINER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/chc_pkg.sv @@
// Shared constants and codes of the convex hull line container.
package chc_pkg;

  localparam int CHC_CAPACITY = 64;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int X_W     = 32;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 7;

  // differences of intercepts and slopes used by the redundancy test
  localparam int DB_W = ICPT_W + 1;
  localparam int DA_W = SLOPE_W + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DROP  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

endpackage

@@ hw/rtl/convex_hull_line_container.sv @@
// Top level of the convex hull line container: line table, sequencer, query scan.
//
// Usage: words enter on s_axis (tuser = cmd, tdata = slope, intercept, query_x) and
// one result word per input leaves on m_axis (best_value, status, line_count).
// Lines are kept sorted by slope in one single-port-read memory (one read and one
// write per cycle, registered read data). One item is worked on at a time.
// Query: one table entry read per cycle into a 32x32 multiplier and a compare stage.
// Insert: a slope search, then either an overwrite in place of an equal slope or a shift
// of the upper part of the table to open a slot, then redundancy tests (three reads
// and two bit-serial 49x33 products each), and a shift down for each line removed.
// Writing max_mode empties the table; write it only while the block is idle.
// Reset empties the table and selects the lower envelope; the memory is not
// cleared, entries are only read below the held count.
// A finished result waits in the output register while m_axis_tready is low; the
// next input word is taken only after that result has been loaded.
`include "convex_hull_line_container_defines.svh"

module convex_hull_line_container import chc_pkg::*; #(
  parameter int CAPACITY = CHC_CAPACITY
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // max_mode
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // slope[31:0], intercept[79:32], query_x[111:80]
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata   // best_value[63:0], status[65:64], line_count[72:66]
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int EW   = SLOPE_W + ICPT_W;
  localparam int PW   = DB_W + DA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SHUP, S_PUT, S_CK, S_CK_DIF, S_CK_GO, S_CK_MUL,
    S_RM, S_QUERY, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    CTX_SELF, CTX_LEFT, CTX_RIGHT
  } ctx_t;

  state_t st;
  ctx_t   ctx;

  logic            max_mode;
  logic [CNTW-1:0] held;
  logic [CNTW-1:0] k;
  logic [CNTW-1:0] p;
  logic [CNTW-1:0] ck_i;
  logic [1:0]      ck_k;
  logic [1:0]      ck_c;
  logic            rv;
  logic [IW-1:0]   ridx;

  logic [SLOPE_W-1:0] a_in;
  logic [ICPT_W-1:0]  b_in;
  logic [X_W-1:0]     x_in;

  logic [SLOPE_W-1:0] l_a, m_a, r_a;
  logic [ICPT_W-1:0]  l_b, m_b, r_b;
  logic signed [DB_W-1:0] d_b1, d_b2;
  logic signed [DA_W-1:0] d_a1, d_a2;
  logic signed [PW-1:0]   prod1, prod2;
  logic                   m_done1, m_done2, m_start;

  logic                    pv;
  logic                    first;
  logic signed [VAL_W-1:0] qprod;
  logic [ICPT_W-1:0]       qb;
  logic signed [VAL_W-1:0] acc;
  logic signed [VAL_W-1:0] q_v;
  logic                    q_better;

  logic [VAL_W-1:0] res_best;
  status_t          res_status;

  // line memory: {intercept, slope}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic [SLOPE_W-1:0] rd_slope;
  logic [ICPT_W-1:0]  rd_icpt;

  logic srch_hit, srch_eq, better, ck_triv, ck_done, ck_red, in_acc;

  assign rd_slope = rd_q[SLOPE_W-1:0];
  assign rd_icpt  = rd_q[EW-1:SLOPE_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // search and check conditions
  always_comb begin
    srch_hit = rv && ($signed(rd_slope) >= $signed(a_in));
    srch_eq  = rv && (rd_slope == a_in);
    better   = max_mode ? ($signed(rd_icpt) < $signed(b_in))
                        : ($signed(rd_icpt) > $signed(b_in));
    ck_triv  = (ck_i == '0) || (((CNTW+1)'(ck_i) + 1'b1) >= (CNTW+1)'(held));
    ck_done  = ((st == S_CK) && ck_triv) || ((st == S_CK_MUL) && m_done1);
    ck_red   = (st == S_CK_MUL) && (prod1 <= prod2);
    q_v      = qprod + {{(VAL_W-ICPT_W){qb[ICPT_W-1]}}, qb};
    q_better = first || (max_mode ? (q_v > acc) : (q_v < acc));
    m_start  = (st == S_CK_GO);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = ridx;
    wr_data = rd_q;
    unique case (st)
      S_SEARCH: begin
        rd_en   = (k < held) && !srch_hit;
        wr_en   = srch_eq && better;
        wr_data = {b_in, a_in};
      end
      S_SHUP: begin
        rd_en   = (k > p);
        rd_addr = IW'(k - 1'b1);
        wr_en   = rv;
        wr_addr = ridx + 1'b1;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = p[IW-1:0];
        wr_data = {b_in, a_in};
      end
      S_CK: begin
        rd_en   = !ck_triv && (ck_k < 2'd3);
        rd_addr = IW'(ck_i - 1'b1 + CNTW'(ck_k));
      end
      S_RM: begin
        rd_en   = (k < held);
        wr_en   = rv;
        wr_addr = ridx - 1'b1;
      end
      S_QUERY: begin
        rd_en   = (k < held);
      end
      default: begin
      end
    endcase
  end

  chc_mul #(.AW(DB_W), .BW(DA_W)) u_mul1 (
    .clk(clk), .rst(rst), .start(m_start), .op_a(d_b1), .op_b(d_a1),
    .done(m_done1), .prod(prod1)
  );

  chc_mul #(.AW(DB_W), .BW(DA_W)) u_mul2 (
    .clk(clk), .rst(rst), .start(m_start), .op_a(d_b2), .op_b(d_a2),
    .done(m_done2), .prod(prod2)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      ctx           <= CTX_SELF;
      held          <= '0;
      max_mode      <= 1'b0;
      rv            <= 1'b0;
      pv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rv   <= rd_en;
      ridx <= rd_addr;
      if (m_axis_tvalid && m_axis_tready && (st != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_acc) begin
            a_in     <= s_axis_tdata[31:0];
            b_in     <= s_axis_tdata[79:32];
            x_in     <= s_axis_tdata[111:80];
            res_best <= '0;
            k        <= '0;
            first    <= 1'b1;
            if (s_axis_tuser == CMD_INSERT) begin
              st <= S_SEARCH;
            end else if (held == '0) begin
              res_status <= ST_EMPTY;
              st         <= S_OUT;
            end else begin
              st <= S_QUERY;
            end
          end
        end
        S_SEARCH: begin
          if (rd_en) begin
            k <= k + 1'b1;
          end
          if (srch_hit) begin
            p <= CNTW'(ridx);
            if (srch_eq) begin
              if (better) begin
                ck_i <= CNTW'(ridx);
                ctx  <= CTX_SELF;
                ck_k <= '0;
                ck_c <= '0;
                st   <= S_CK;
              end else begin
                res_status <= ST_DROP;
                st         <= S_OUT;
              end
            end else if (held == CNTW'(CAPACITY)) begin
              res_status <= ST_FULL;
              st         <= S_OUT;
            end else begin
              k  <= held;
              st <= S_SHUP;
            end
          end else if (!rv && (k == held)) begin
            p <= held;
            if (held == CNTW'(CAPACITY)) begin
              res_status <= ST_FULL;
              st         <= S_OUT;
            end else begin
              st <= S_SHUP;
            end
          end
        end
        S_SHUP: begin
          if (rd_en) begin
            k <= k - 1'b1;
          end else if (!rv) begin
            st <= S_PUT;
          end
        end
        S_PUT: begin
          held <= held + 1'b1;
          ck_i <= p;
          ctx  <= CTX_SELF;
          ck_k <= '0;
          ck_c <= '0;
          st   <= S_CK;
        end
        S_CK: begin
          if (rd_en) begin
            ck_k <= ck_k + 1'b1;
          end
          if (rv) begin
            ck_c <= ck_c + 1'b1;
            unique case (ck_c)
              2'd0: begin
                l_a <= rd_slope;
                l_b <= rd_icpt;
              end
              2'd1: begin
                m_a <= rd_slope;
                m_b <= rd_icpt;
              end
              default: begin
                r_a <= rd_slope;
                r_b <= rd_icpt;
                st  <= S_CK_DIF;
              end
            endcase
          end
        end
        S_CK_DIF: begin
          // cross-product operands of the chosen envelope
          d_b1 <= $signed({l_b[ICPT_W-1], l_b}) - $signed({r_b[ICPT_W-1], r_b});
          d_a2 <= $signed({r_a[SLOPE_W-1], r_a}) - $signed({l_a[SLOPE_W-1], l_a});
          if (max_mode) begin
            d_a1 <= $signed({m_a[SLOPE_W-1], m_a}) - $signed({l_a[SLOPE_W-1], l_a});
            d_b2 <= $signed({l_b[ICPT_W-1], l_b}) - $signed({m_b[ICPT_W-1], m_b});
          end else begin
            d_a1 <= $signed({r_a[SLOPE_W-1], r_a}) - $signed({m_a[SLOPE_W-1], m_a});
            d_b2 <= $signed({m_b[ICPT_W-1], m_b}) - $signed({r_b[ICPT_W-1], r_b});
          end
          st <= S_CK_GO;
        end
        S_CK_GO: begin
          st <= S_CK_MUL;
        end
        S_CK_MUL: begin
        end
        S_RM: begin
          if (rd_en) begin
            k <= k + 1'b1;
          end else if (!rv) begin
            held <= held - 1'b1;
            ck_k <= '0;
            ck_c <= '0;
            unique case (ctx)
              CTX_SELF: begin
                res_status <= ST_DROP;
                st         <= S_OUT;
              end
              CTX_LEFT: begin
                p  <= p - 1'b1;
                st <= S_CK;
                if (p != CNTW'(1)) begin
                  ck_i <= p - 2'd2;
                end else begin
                  ck_i <= p;
                  ctx  <= CTX_RIGHT;
                end
              end
              default: begin
                ck_i <= p + 1'b1;
                st   <= S_CK;
              end
            endcase
          end
        end
        S_QUERY: begin
          if (rd_en) begin
            k <= k + 1'b1;
          end
          pv    <= rv;
          qprod <= $signed(rd_slope) * $signed(x_in);
          qb    <= rd_icpt;
          if (pv && q_better) begin
            acc   <= q_v;
            first <= 1'b0;
          end
          if (!rd_en && !rv && !pv) begin
            res_best   <= acc;
            res_status <= ST_OK;
            st         <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, 7'(held), res_status, res_best};
            st            <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase

      // verdict of a redundancy test
      if (ck_done) begin
        ck_k <= '0;
        ck_c <= '0;
        unique case (ctx)
          CTX_SELF: begin
            if (ck_red) begin
              k  <= p + 1'b1;
              st <= S_RM;
            end else if (p != '0) begin
              ck_i <= p - 1'b1;
              ctx  <= CTX_LEFT;
              st   <= S_CK;
            end else begin
              ck_i <= p + 1'b1;
              ctx  <= CTX_RIGHT;
              st   <= S_CK;
            end
          end
          CTX_LEFT: begin
            if (ck_red) begin
              k  <= p;
              st <= S_RM;
            end else begin
              ck_i <= p + 1'b1;
              ctx  <= CTX_RIGHT;
              st   <= S_CK;
            end
          end
          default: begin
            if (ck_red) begin
              k  <= p + 2'd2;
              st <= S_RM;
            end else begin
              res_status <= ST_OK;
              st         <= S_OUT;
            end
          end
        endcase
      end

      // mode change empties the table
      if (cfg_wr_en) begin
        max_mode <= cfg_wr_data;
        held     <= '0;
      end
    end
  end

  `CHC_ASSERT_IMP(a_held_cap, 1'b1, held <= CNTW'(CAPACITY), "held count above capacity")
  `CHC_ASSERT_NXT(a_leave_idle, in_acc, st != S_IDLE, "accepted word left block idle")
  `CHC_ASSERT_IMP(a_port_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write same entry")
  `CHC_ASSERT_IMP(a_mul_pair, m_done1 || m_done2, m_done1 && m_done2, "multipliers out of step")

endmodule

@@ hw/rtl/chc_mul.sv @@
// Bit-serial signed multiplier for the redundancy cross products.
module chc_mul import chc_pkg::*; #(
  parameter int AW = DB_W,
  parameter int BW = DA_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AW-1:0]     op_a,
  input  logic signed [BW-1:0]     op_b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_mag;
  logic [BW-1:0] b_mag;
  logic [PW-1:0] mc;
  logic [PW-1:0] acc;
  logic [BW-1:0] mb;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          run;
  logic          fin;

  // magnitudes of the operands
  assign a_mag = op_a[AW-1] ? (~op_a + 1'b1) : op_a;
  assign b_mag = op_b[BW-1] ? (~op_b + 1'b1) : op_b;

  // one multiplier bit per cycle, sign applied at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(BW);
        mc  <= PW'(a_mag);
        mb  <= b_mag;
        acc <= '0;
        neg <= op_a[AW-1] ^ op_b[BW-1];
      end else if (run) begin
        if (mb[0]) begin
          acc <= acc + mc;
        end
        mc  <= mc << 1;
        mb  <= mb >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        prod <= neg ? (~acc + 1'b1) : acc;
      end
    end
  end

endmodule
